// ===== design/lpr_pkg.sv =====
// Shared constants for the LRU page replacement block.
// No dependencies; used by lru_page_replacement.
package lpr_pkg;

  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 20;

  localparam int CFG_W   = 4;
  localparam int INDEX_W = 3;
  localparam int EVICT_W = 20;
  localparam int FAULT_W = 32;

  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(8);
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

endpackage

// ===== design/lpr_cell.sv =====
// One frame of the LRU chain: holds valid mark, page and recency rank,
// folds itself into the search word passed along the chain. Uses lpr_pkg widths only via parent.
module lpr_cell #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 20,
  parameter int IDX       = 0
) (
  clk,
  rst,
  clr,
  act,
  req_page,
  tok_in,
  car_in,
  tok_out,
  car_out,
  upd
);
  localparam int IDX_W  = $clog2(FRAMES);
  localparam int RANK_W = $clog2(FRAMES);
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(FRAMES - 1);
  localparam logic [IDX_W-1:0]  MY_IDX   = IDX_W'(IDX);

  typedef struct packed {
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [RANK_W-1:0]    hit_rank;
    logic                 empty;
    logic [IDX_W-1:0]     empty_idx;
    logic [RANK_W-1:0]    best_rank;
    logic [IDX_W-1:0]     best_idx;
    logic [PAGE_BITS-1:0] best_page;
  } srch_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  sel;
    logic              sel_valid;
    logic [RANK_W-1:0] sel_rank;
  } upd_t;

  input  logic                 clk;
  input  logic                 rst;
  input  logic                 clr;
  input  logic                 act;
  input  logic [PAGE_BITS-1:0] req_page;
  input  logic                 tok_in;
  input  srch_t                car_in;
  output logic                 tok_out;
  output srch_t                car_out;
  input  upd_t                 upd;

  logic                 valid;
  logic [PAGE_BITS-1:0] page;
  logic [RANK_W-1:0]    rank;
  srch_t                car_next;

  always_comb begin
    car_next = car_in;
    if (act) begin
      if (!car_in.hit && valid && (page == req_page)) begin
        car_next.hit      = 1'b1;
        car_next.hit_idx  = MY_IDX;
        car_next.hit_rank = rank;
      end
      if (!car_in.empty && !valid) begin
        car_next.empty     = 1'b1;
        car_next.empty_idx = MY_IDX;
      end
      if ((IDX == 0) || (rank > car_in.best_rank)) begin
        car_next.best_rank = rank;
        car_next.best_idx  = MY_IDX;
        car_next.best_page = page;
      end
    end
  end

  // pass the search word on, one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= 1'b0;
    end else begin
      tok_out <= tok_in;
    end
    if (tok_in) begin
      car_out <= car_next;
    end
  end

  // frame state: clear beats update
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (upd.en) begin
      if (upd.sel == MY_IDX) begin
        valid <= 1'b1;
        rank  <= '0;
      end else if (valid && (!upd.sel_valid || (rank < upd.sel_rank)) && (rank != RANK_MAX)) begin
        rank <= rank + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!clr && upd.en && (upd.sel == MY_IDX)) begin
      page <= req_page;
    end
  end

endmodule

// ===== design/lru_page_replacement.sv =====
// LRU page replacement: top level, chain of FRAMES lpr_cell frames; uses lpr_pkg.
// The result word strobes on done once start is taken and the search has
// swept the cell chain one frame per cycle, followed by a broadcast update.
// One word is in flight at a time; the next start can be taken in its update cycle.
// Reset (rst, synchronous): all frames empty, ranks and fault count zero,
// frames_in_use = 8. Results cannot be stalled by the receiver.
module lru_page_replacement #(
  parameter int FRAMES    = lpr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF
) (
  clk,
  rst,
  cfg_we,
  cfg_wdata,
  start,
  busy,
  page,
  restart,
  done,
  hit,
  frame_index,
  evicted_valid,
  evicted_page,
  fault_count
);
  localparam int IDX_W  = $clog2(FRAMES);
  localparam int RANK_W = $clog2(FRAMES);

  typedef struct packed {
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [RANK_W-1:0]    hit_rank;
    logic                 empty;
    logic [IDX_W-1:0]     empty_idx;
    logic [RANK_W-1:0]    best_rank;
    logic [IDX_W-1:0]     best_idx;
    logic [PAGE_BITS-1:0] best_page;
  } srch_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  sel;
    logic              sel_valid;
    logic [RANK_W-1:0] sel_rank;
  } upd_t;

  input  logic                              clk;
  input  logic                              rst;
  input  logic                              cfg_we;
  input  logic [lpr_pkg::CFG_W-1:0]         cfg_wdata;
  input  logic                              start;
  output logic                              busy;
  input  logic [PAGE_BITS-1:0]              page;
  input  logic                              restart;
  output logic                              done;
  output logic                              hit;
  output logic [lpr_pkg::INDEX_W-1:0]       frame_index;
  output logic                              evicted_valid;
  output logic [lpr_pkg::EVICT_W-1:0]       evicted_page;
  output logic [lpr_pkg::FAULT_W-1:0]       fault_count;

  logic [lpr_pkg::CFG_W-1:0]   frames_in_use;
  logic [lpr_pkg::CFG_W-1:0]   frames_eff;
  logic                        busy_reg;
  logic                        launch;
  logic                        accept;
  logic                        clr;
  logic [PAGE_BITS-1:0]        req_page;
  logic [lpr_pkg::FAULT_W-1:0] faults;
  logic [lpr_pkg::FAULT_W-1:0] faults_next;

  logic [FRAMES-1:0] act;
  logic [FRAMES-1:0] tok;
  logic [FRAMES-1:0] tok_in;
  srch_t             car    [FRAMES];
  srch_t             car_in [FRAMES];
  srch_t             fin;
  logic              tok_last;
  upd_t              upd;

  logic [IDX_W-1:0]  sel;
  logic              ev_valid;

  // configuration register: hold last write; zero acts as one frame
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lpr_pkg::CFG_RESET;
    end else if (cfg_we) begin
      frames_in_use <= cfg_wdata;
    end
  end

  assign frames_eff = (frames_in_use == '0) ? lpr_pkg::CFG_W'(1) : frames_in_use;

  // a frame takes part only below the active count; values above FRAMES
  // activate every frame since no index reaches them
  for (genvar k = 0; k < FRAMES; k++) begin : g_act
    assign act[k] = (32'(frames_eff) > k);
  end

  // handshake: free again in the update cycle, so the next word can follow
  assign tok_last = tok[FRAMES-1];
  assign fin      = car[FRAMES-1];
  assign busy     = busy_reg & ~tok_last;
  assign accept   = start & ~busy;
  assign clr      = accept & restart;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_reg <= 1'b0;
      launch   <= 1'b0;
    end else begin
      launch <= accept;
      if (accept) begin
        busy_reg <= 1'b1;
      end else if (tok_last) begin
        busy_reg <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_page <= page;
    end
  end

  // cell chain: cell 0 starts from an empty search word
  for (genvar k = 0; k < FRAMES; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign tok_in[k] = launch;
      assign car_in[k] = '0;
    end else begin : g_link
      assign tok_in[k] = tok[k-1];
      assign car_in[k] = car[k-1];
    end

    lpr_cell #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS),
      .IDX       (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .clr      (clr),
      .act      (act[k]),
      .req_page (req_page),
      .tok_in   (tok_in[k]),
      .car_in   (car_in[k]),
      .tok_out  (tok[k]),
      .car_out  (car[k]),
      .upd      (upd)
    );
  end

  // decision at the chain end: hit, else lowest empty frame, else the oldest
  always_comb begin
    ev_valid = ~fin.hit & ~fin.empty;
    if (fin.hit) begin
      sel = fin.hit_idx;
    end else if (fin.empty) begin
      sel = fin.empty_idx;
    end else begin
      sel = fin.best_idx;
    end

    upd.en        = tok_last;
    upd.sel       = sel;
    upd.sel_valid = fin.hit | ~fin.empty;
    upd.sel_rank  = fin.hit ? fin.hit_rank : fin.best_rank;

    if (fin.hit || (faults == lpr_pkg::FAULT_MAX)) begin
      faults_next = faults;
    end else begin
      faults_next = faults + lpr_pkg::FAULT_W'(1);
    end
  end

  // fault counter: a restart taken in the update cycle still wins
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      faults <= '0;
    end else if (tok_last) begin
      faults <= faults_next;
    end
  end

  // result word: done strobes for one cycle; the other fields hold until the next result
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tok_last;
    end
    if (tok_last) begin
      hit           <= fin.hit;
      frame_index   <= lpr_pkg::INDEX_W'(sel);
      evicted_valid <= ev_valid;
      evicted_page  <= ev_valid ? lpr_pkg::EVICT_W'(fin.best_page) : '0;
      fault_count   <= faults_next;
    end
  end

endmodule
